[hdl/bsqrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bsqrt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int SEED_BITS  = 15;
  localparam int SQ_BITS    = 2 * SEED_BITS;
  localparam int CMP_BITS   = (VALUE_BITS > SQ_BITS) ? VALUE_BITS : SQ_BITS;
  localparam int ROUNDS_W   = 6;
  localparam int TOL_W      = 5;

  localparam int S_DATA_W   = ((VALUE_BITS + SEED_BITS + 7) / 8) * 8;
  localparam int M_DATA_W   = ((SEED_BITS + 7) / 8) * 8;
  localparam int ADDR_W     = 3;
  localparam int PDATA_W    = 32;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = ROUNDS_W'(20);
  localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(8);

  // register index, taken from paddr[2]
  localparam logic REG_MAX_ROUNDS = 1'b0;
  localparam logic REG_TOL_SHIFT  = 1'b1;

  typedef struct packed {
    logic load;    // capture a new word and seed the bounds
    logic square;  // register guess * guess
    logic step;    // move guess and one bound
    logic emit;    // copy guess into the output register
  } cmd_t;

  typedef struct packed {
    logic hit;     // |value - square| within tolerance
  } sts_t;

endpackage
`default_nettype wire

[hdl/bisection_square_root.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bisection square root. Each input word carries a value and an upper-bound
// seed; the block returns one 15-bit root per word. The search starts with
// guess = seed/2 between bounds 0 and seed, squares the guess, and halves
// the interval toward the root until |value - guess^2| <= value >> tol_shift,
// or max_rounds rounds have run (exact hits stop at once). From acceptance
// to output-register load an item runs R rounds (0..max_rounds), each one
// passing through the 15x15 squaring register and then compare and bound
// update, with one multiplier and one comparator serving every round. One
// item is worked on at a time; a finished root sits in the output register
// so the next word can be accepted while the downstream side stalls.
// Registers: max_rounds at byte 0x0 (6 bits, reset 20), tol_shift at 0x4
// (5 bits, reset 8); only paddr[2] is decoded. Write them only while the
// block is idle.
module bisection_square_root (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input word: [30:0] square_value, [45:31] upper_seed, [47:46] zero
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [bsqrt_pkg::S_DATA_W-1:0]      s_tdata,
  // output word: [14:0] root, [15] zero
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [bsqrt_pkg::M_DATA_W-1:0]      m_tdata,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bsqrt_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [bsqrt_pkg::PDATA_W-1:0]       pwdata,
  output logic      [bsqrt_pkg::PDATA_W-1:0]       prdata,
  output logic                                     pready
);

  localparam int VB = bsqrt_pkg::VALUE_BITS;
  localparam int SB = bsqrt_pkg::SEED_BITS;

  logic [bsqrt_pkg::ROUNDS_W-1:0] max_rounds;
  logic [bsqrt_pkg::TOL_W-1:0]    tol_shift;
  bsqrt_pkg::cmd_t                cmd;
  bsqrt_pkg::sts_t                sts;
  logic [SB-1:0]                  root;

  bsqrt_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_rounds_o (max_rounds),
    .tol_shift_o  (tol_shift)
  );

  // sequencer: accept, square, compare/step, hand off to output register
  bsqrt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_o   (s_tready),
    .m_tvalid_o   (m_tvalid),
    .m_tready_i   (m_tready),
    .max_rounds_i (max_rounds),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // bounds, guess, squaring register and output register
  bsqrt_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .val_i       (s_tdata[VB-1:0]),
    .seed_i      (s_tdata[VB+SB-1:VB]),
    .tol_shift_i (tol_shift),
    .sts_o       (sts),
    .root_o      (root)
  );

  assign m_tdata = bsqrt_pkg::M_DATA_W'(root);

endmodule
`default_nettype wire

[hdl/bsqrt_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module bsqrt_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bsqrt_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [bsqrt_pkg::PDATA_W-1:0]      pwdata,
  output logic      [bsqrt_pkg::PDATA_W-1:0]      prdata,
  output logic                                    pready,
  output logic      [bsqrt_pkg::ROUNDS_W-1:0]     max_rounds_o,
  output logic      [bsqrt_pkg::TOL_W-1:0]        tol_shift_o
);

  logic [bsqrt_pkg::ROUNDS_W-1:0] max_rounds_q;
  logic [bsqrt_pkg::TOL_W-1:0]    tol_shift_q;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rounds_q <= bsqrt_pkg::ROUNDS_RESET;
      tol_shift_q  <= bsqrt_pkg::TOL_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bsqrt_pkg::REG_MAX_ROUNDS: max_rounds_q <= pwdata[bsqrt_pkg::ROUNDS_W-1:0];
        bsqrt_pkg::REG_TOL_SHIFT:  tol_shift_q  <= pwdata[bsqrt_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bsqrt_pkg::REG_MAX_ROUNDS:
        prdata = {{(bsqrt_pkg::PDATA_W-bsqrt_pkg::ROUNDS_W){1'b0}}, max_rounds_q};
      bsqrt_pkg::REG_TOL_SHIFT:
        prdata = {{(bsqrt_pkg::PDATA_W-bsqrt_pkg::TOL_W){1'b0}}, tol_shift_q};
      default: prdata = '0;
    endcase
  end

  assign max_rounds_o = max_rounds_q;
  assign tol_shift_o  = tol_shift_q;

endmodule
`default_nettype wire

[hdl/bsqrt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module bsqrt_dp (
  input  wire logic                                clk_i,
  input  wire bsqrt_pkg::cmd_t                     cmd_i,
  input  wire logic [bsqrt_pkg::VALUE_BITS-1:0]    val_i,
  input  wire logic [bsqrt_pkg::SEED_BITS-1:0]     seed_i,
  input  wire logic [bsqrt_pkg::TOL_W-1:0]         tol_shift_i,
  output bsqrt_pkg::sts_t                          sts_o,
  output logic      [bsqrt_pkg::SEED_BITS-1:0]     root_o
);

  localparam int CW = bsqrt_pkg::CMP_BITS;
  localparam int SW = bsqrt_pkg::SEED_BITS;

  logic [bsqrt_pkg::VALUE_BITS-1:0] val_q, tol_q;
  logic [SW-1:0]                    guess_q, lo_q, hi_q, root_q;
  logic [bsqrt_pkg::SQ_BITS-1:0]    sq_q, prod;
  logic [CW-1:0]                    val_x, sq_x, tol_x, mag;
  logic                             up;
  logic [SW:0]                      sum_up, sum_dn;

  assign prod = guess_q * guess_q;

  always_comb begin
    val_x  = CW'(val_q);
    sq_x   = CW'(sq_q);
    tol_x  = CW'(tol_q);
    up     = val_x > sq_x;
    mag    = up ? (val_x - sq_x) : (sq_x - val_x);
    sum_up = {1'b0, guess_q} + {1'b0, hi_q};
    sum_dn = {1'b0, guess_q} + {1'b0, lo_q};
  end

  assign sts_o.hit = (mag <= tol_x);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q   <= val_i;
      tol_q   <= val_i >> tol_shift_i;
      guess_q <= seed_i >> 1;
      hi_q    <= seed_i;
      lo_q    <= '0;
    end else if (cmd_i.step) begin
      if (up) begin
        lo_q    <= guess_q;
        guess_q <= sum_up[SW:1];
      end else begin
        hi_q    <= guess_q;
        guess_q <= sum_dn[SW:1];
      end
    end
    if (cmd_i.square) begin
      sq_q <= prod;
    end
    if (cmd_i.emit) begin
      root_q <= guess_q;
    end
  end

  assign root_o = root_q;

endmodule
`default_nettype wire

[hdl/bsqrt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bsqrt_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  input  wire logic [bsqrt_pkg::ROUNDS_W-1:0]   max_rounds_i,
  input  wire bsqrt_pkg::sts_t                  sts_i,
  output bsqrt_pkg::cmd_t                       cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [bsqrt_pkg::ROUNDS_W-1:0] rounds_q, rounds_d;
  logic                           ovalid_q, ovalid_d;
  logic                           out_free;

  assign out_free   = !ovalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    rounds_d = rounds_q;
    ovalid_d = ovalid_q && !m_tready_i;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          rounds_d   = '0;
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if ((rounds_q >= max_rounds_i) || sts_i.hit) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          rounds_d   = rounds_q + 1'b1;
          state_d    = ST_SQ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rounds_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rounds_q <= rounds_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

[hdl/bsqrt_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module bsqrt_chk (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid,
  input  wire logic                              s_tready,
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic [bsqrt_pkg::M_DATA_W-1:0]    m_tdata,
  input  wire logic                              pready
);

  // stalled output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word dropped or changed while stalled");

  // one word in flight: after an accept, input stays closed through the shortest search (square, compare, done)
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input reopened before the search finished");

  // a new result only appears out of a state in which the input is closed
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an item in work");

  // padding bit of the output word is zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[bsqrt_pkg::M_DATA_W-1] == 1'b0))
    else $error("output padding not zero");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind bisection_square_root bsqrt_chk u_bsqrt_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
`default_nettype wire
